// File: src/fpp_pkg.sv
`default_nettype none
package fpp_pkg;

   localparam int GAIN_W      = 16;
   localparam int LIMIT_W     = 23;
   localparam int DRIVE_W     = 32;
   localparam int WEIGHT_BITS = 8;
   localparam int GAIN_FRAC   = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int RSP_W       = ((DRIVE_W + 1 + 7) / 8) * 8;

   localparam logic signed [GAIN_W-1:0] WEIGHT_NEW = 16'sd179;
   localparam logic signed [GAIN_W-1:0] WEIGHT_OLD = 16'sd77;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P      = 2'd0,
      CSR_GAIN_I      = 2'd1,
      CSR_GAIN_D      = 2'd2,
      CSR_INTEG_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_NEW,
      ST_MUL_OLD,
      ST_ERR,
      ST_INTEG,
      ST_MUL_I,
      ST_MUL_D,
      ST_SUM,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      MUL_NEW,
      MUL_OLD,
      MUL_P,
      MUL_I,
      MUL_D
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        err_en;
      logic        integ_en;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// File: src/filtered_position_pid.sv
// Channel  Direction  Transaction
// req_     in         tdata = measured_position, target_position (from bit 0 up)
// rsp_     out        tdata = drive, integral_clamped (from bit 0 up)
// csr_     in         write of one gain or the integral limit per enabled cycle
//
// An accepted item passes through the steps MUL_NEW, MUL_OLD, ERR, INTEG, MUL_I,
// MUL_D, SUM and OUT to the result register, and no item is accepted meanwhile:
// one shared 16-bit-gain multiplier runs five products in turn (two filter taps,
// P, I, D).
// A new item is accepted only once the previous one has reached the output
// register; the result waits there while the next item computes.
// A stalled result holds the controller in its final step.
// Reset is synchronous; it clears gains, limit, filter, previous error, integral and output valid.
`default_nettype none
module filtered_position_pid
   import fpp_pkg::*;
#(
   parameter int POSITION_WIDTH = 16,
   parameter int FRAC_BITS      = 8
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_tvalid,
   output logic                                             req_tready,
   // measured_position, target_position
   input  wire logic [((2*POSITION_WIDTH+7)/8)*8-1:0]       req_tdata,
   output logic                                             rsp_tvalid,
   input  wire logic                                        rsp_tready,
   // drive, integral_clamped
   output logic [RSP_W-1:0]                                 rsp_tdata,
   input  wire logic                                        csr_wen,
   input  wire logic [CSR_IDX_W-1:0]                        csr_addr,
   input  wire logic [LIMIT_W-1:0]                          csr_wdata
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [DRIVE_W-1:0] drive;
   logic               integral_clamped;

   fpp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fpp_dp #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .FRAC_BITS      (FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .measured_position (req_tdata[POSITION_WIDTH-1:0]),
      .target_position   (req_tdata[2*POSITION_WIDTH-1:POSITION_WIDTH]),
      .csr_wen           (csr_wen),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .drive             (drive),
      .integral_clamped  (integral_clamped),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready)
   );

   assign rsp_tdata = {{(RSP_W - DRIVE_W - 1){1'b0}}, integral_clamped, drive};

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new transaction accepted while one is in progress");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after acceptance");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not idle after reset");
`endif

endmodule
`default_nettype wire

// File: src/fpp_ctrl.sv
`default_nettype none
module fpp_ctrl
   import fpp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_MUL_NEW;
         ST_MUL_NEW: state_in = ST_MUL_OLD;
         ST_MUL_OLD: state_in = ST_ERR;
         ST_ERR:     state_in = ST_INTEG;
         ST_INTEG:   state_in = ST_MUL_I;
         ST_MUL_I:   state_in = ST_MUL_D;
         ST_MUL_D:   state_in = ST_SUM;
         ST_SUM:     state_in = ST_OUT;
         ST_OUT:     if (status.out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.mul_sel = MUL_NEW;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ST_MUL_NEW: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_NEW;
         end
         ST_MUL_OLD: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_OLD;
            cmd.acc_load = 1'b1;
         end
         ST_ERR: begin
            cmd.err_en = 1'b1;
         end
         ST_INTEG: begin
            cmd.integ_en = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_P;
         end
         ST_MUL_I: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_I;
            cmd.acc_load = 1'b1;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_D;
            cmd.acc_add = 1'b1;
         end
         ST_SUM: begin
            cmd.acc_add = 1'b1;
         end
         ST_OUT: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: src/fpp_dp.sv
`default_nettype none
module fpp_dp
   import fpp_pkg::*;
#(
   parameter int POSITION_WIDTH = 16,
   parameter int FRAC_BITS      = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dp_cmd_type                  cmd,
   output dp_status_type                    status,
   input  wire logic [POSITION_WIDTH-1:0]   measured_position,
   input  wire logic [POSITION_WIDTH-1:0]   target_position,
   input  wire logic                        csr_wen,
   input  wire logic [CSR_IDX_W-1:0]        csr_addr,
   input  wire logic [LIMIT_W-1:0]          csr_wdata,
   output logic [DRIVE_W-1:0]               drive,
   output logic                             integral_clamped,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready
);

   localparam int POS_Q_W  = POSITION_WIDTH + FRAC_BITS;
   localparam int ERR_W    = POS_Q_W + 1;
   localparam int DERIV_W  = ERR_W + 1;
   localparam int INTEG_W  = LIMIT_W + FRAC_BITS + 1;
   localparam int SUM_W    = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 1;
   localparam int LIM_PAD  = SUM_W - LIMIT_W - FRAC_BITS;
   localparam int MUL_A_W  = (INTEG_W > DERIV_W) ? INTEG_W : DERIV_W;
   localparam int PROD_W   = MUL_A_W + GAIN_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int TRUNC_SH = GAIN_FRAC + FRAC_BITS;
   localparam int QUOT_W   = ACC_W - TRUNC_SH;
   localparam logic [ACC_W-1:0] RND_MASK = {{(ACC_W - TRUNC_SH){1'b0}}, {TRUNC_SH{1'b1}}};

   // configuration
   logic signed [GAIN_W-1:0]  gain_p_ff, gain_p_in;
   logic signed [GAIN_W-1:0]  gain_i_ff, gain_i_in;
   logic signed [GAIN_W-1:0]  gain_d_ff, gain_d_in;
   logic [LIMIT_W-1:0]        limit_ff,  limit_in;

   // loop state
   logic signed [POS_Q_W-1:0] filt_ff,  filt_in;
   logic signed [ERR_W-1:0]   prev_ff,  prev_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;

   // working registers
   logic signed [POSITION_WIDTH-1:0] meas_ff, meas_in;
   logic signed [POSITION_WIDTH-1:0] targ_ff, targ_in;
   logic signed [ERR_W-1:0]   err_ff,   err_in;
   logic signed [DERIV_W-1:0] deriv_ff, deriv_in;
   logic                      clamp_ff, clamp_in;
   logic signed [PROD_W-1:0]  prod_ff,  prod_in;
   logic signed [ACC_W-1:0]   acc_ff,   acc_in;

   // output register
   logic [DRIVE_W-1:0]        drive_ff,  drive_in;
   logic                      oclamp_ff, oclamp_in;
   logic                      ovalid_ff, ovalid_in;

   logic signed [POS_Q_W-1:0] meas_q, targ_q, filt;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [GAIN_W-1:0]  mul_b;
   logic signed [ACC_W-1:0]   fsum;
   logic signed [SUM_W-1:0]   sum, lim_pos, lim_neg, sum_sat;
   logic                      sum_hi, sum_lo;
   logic [ACC_W-1:0]          acc_adj;
   logic [QUOT_W-1:0]         quot;
   logic                      quot_ovf;

   assign status.out_free  = !ovalid_ff || rsp_ready;
   assign drive            = drive_ff;
   assign integral_clamped = oclamp_ff;
   assign rsp_valid        = ovalid_ff;

   assign meas_q = $signed({meas_ff, {FRAC_BITS{1'b0}}});
   assign targ_q = $signed({targ_ff, {FRAC_BITS{1'b0}}});

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_NEW: begin
            mul_a = MUL_A_W'(meas_q);
            mul_b = WEIGHT_NEW;
         end
         MUL_OLD: begin
            mul_a = MUL_A_W'(filt_ff);
            mul_b = WEIGHT_OLD;
         end
         MUL_P: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = gain_p_ff;
         end
         MUL_I: begin
            mul_a = MUL_A_W'(integ_ff);
            mul_b = gain_i_ff;
         end
         MUL_D: begin
            mul_a = MUL_A_W'(deriv_ff);
            mul_b = gain_d_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // filter: floor of the weighted sum over the weight scale
   assign fsum = acc_ff + ACC_W'(prod_ff);
   assign filt = $signed(fsum[WEIGHT_BITS +: POS_Q_W]);

   // integral with clamp
   assign sum     = SUM_W'(integ_ff) + SUM_W'(err_ff);
   assign lim_pos = $signed({{LIM_PAD{1'b0}}, limit_ff, {FRAC_BITS{1'b0}}});
   assign lim_neg = -lim_pos;
   assign sum_hi  = sum > lim_pos;
   assign sum_lo  = sum < lim_neg;
   assign sum_sat = sum_hi ? lim_pos : (sum_lo ? lim_neg : sum);

   // drive: truncate toward zero, then saturate
   assign acc_adj  = acc_ff[ACC_W-1] ? (acc_ff + RND_MASK) : acc_ff;
   assign quot     = acc_adj[ACC_W-1:TRUNC_SH];
   assign quot_ovf = !((&quot[QUOT_W-1:DRIVE_W-1]) || !(|quot[QUOT_W-1:DRIVE_W-1]));

   always_comb begin
      gain_p_in = gain_p_ff;
      gain_i_in = gain_i_ff;
      gain_d_in = gain_d_ff;
      limit_in  = limit_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            CSR_GAIN_P:      gain_p_in = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_GAIN_I:      gain_i_in = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_GAIN_D:      gain_d_in = $signed(csr_wdata[GAIN_W-1:0]);
            CSR_INTEG_LIMIT: limit_in  = csr_wdata;
            default:         limit_in  = limit_ff;
         endcase
      end

      meas_in = cmd.load_in ? $signed(measured_position) : meas_ff;
      targ_in = cmd.load_in ? $signed(target_position) : targ_ff;

      prod_in = cmd.mul_en ? PROD_W'(mul_a * mul_b) : prod_ff;

      acc_in = acc_ff;
      if (cmd.acc_load) begin
         acc_in = ACC_W'(prod_ff);
      end else if (cmd.acc_add) begin
         acc_in = fsum;
      end

      filt_in = cmd.err_en ? filt : filt_ff;
      err_in  = cmd.err_en ? (ERR_W'(filt) - ERR_W'(targ_q)) : err_ff;

      integ_in = integ_ff;
      prev_in  = prev_ff;
      deriv_in = deriv_ff;
      clamp_in = clamp_ff;
      if (cmd.integ_en) begin
         integ_in = sum_sat[INTEG_W-1:0];
         prev_in  = err_ff;
         deriv_in = DERIV_W'(err_ff) - DERIV_W'(prev_ff);
         clamp_in = sum_hi || sum_lo;
      end

      drive_in  = drive_ff;
      oclamp_in = oclamp_ff;
      ovalid_in = ovalid_ff;
      if (cmd.out_load) begin
         if (quot_ovf) begin
            drive_in = quot[QUOT_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                      : {1'b0, {(DRIVE_W-1){1'b1}}};
         end else begin
            drive_in = quot[DRIVE_W-1:0];
         end
         oclamp_in = clamp_ff;
         ovalid_in = 1'b1;
      end else if (rsp_ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         limit_ff  <= '0;
         filt_ff   <= '0;
         prev_ff   <= '0;
         integ_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         gain_p_ff <= gain_p_in;
         gain_i_ff <= gain_i_in;
         gain_d_ff <= gain_d_in;
         limit_ff  <= limit_in;
         filt_ff   <= filt_in;
         prev_ff   <= prev_in;
         integ_ff  <= integ_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff   <= meas_in;
      targ_ff   <= targ_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      err_ff    <= err_in;
      deriv_ff  <= deriv_in;
      clamp_ff  <= clamp_in;
      drive_ff  <= drive_in;
      oclamp_ff <= oclamp_in;
   end

endmodule
`default_nettype wire
